[rtl/periodic_tick_task_scheduler_top_defines.svh]
// assertion macros for the periodic tick task scheduler
`ifndef PERIODIC_TICK_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TICK_TASK_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, disabled in reset
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

[rtl/pts_pkg.sv]
package pts_pkg;

  // default table depth
  localparam int MAX_TASKS_DEF = 8;

  // field widths
  localparam int OP_W     = 2;
  localparam int TASK_ID_W = 4;
  localparam int TIME_W   = 32;
  localparam int REL_W    = 3;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_SUSPEND = 2'd2;
  localparam logic [OP_W-1:0] OP_RESUME  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic latch;       // capture the request word, restart the scan
    logic apply;       // execute create, suspend or resume and load its result
    logic step;        // update the current slot and move to the next
    logic load_mid;    // emit the pending release, not final
    logic load_final;  // emit the closing tick result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;         // current slot is active with a zero countdown
    logic scan_last;   // current slot is the last one
    logic pend_valid;  // a release is held back waiting for its successor
  } stat_t;

endpackage

[rtl/pts_if.sv]
// request channel
interface pts_req_if;
  logic                             valid;
  logic                             ready;
  logic [pts_pkg::OP_W-1:0]         op;
  logic [pts_pkg::TASK_ID_W-1:0]    task_id;
  logic [pts_pkg::TIME_W-1:0]       start_delay;
  logic [pts_pkg::TIME_W-1:0]       period;
  logic                             start_active;

  modport source (output valid, op, task_id, start_delay, period, start_active,
                  input ready);
  modport sink   (input valid, op, task_id, start_delay, period, start_active,
                  output ready);
endinterface

// response channel
interface pts_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             released;
  logic [pts_pkg::REL_W-1:0]        released_task;
  logic                             last;
  logic [pts_pkg::STATUS_W-1:0]     status;

  modport source (output valid, released, released_task, last, status,
                  input ready);
  modport sink   (input valid, released, released_task, last, status,
                  output ready);
endinterface

[rtl/pts_ctrl.sv]
module pts_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [pts_pkg::OP_W-1:0]  req_op,
  output logic                      req_ready,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  input  pts_pkg::stat_t            stat,
  output pts_pkg::cmd_t             cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       out_load;

  // output register can take a word this cycle
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = (req_op == pts_pkg::OP_TICK) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.apply  = 1'b1;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // a second release must wait until the held one can be sent
        if (!(stat.hit && stat.pend_valid && !out_free)) begin
          cmd.step = 1'b1;
          if (stat.hit && stat.pend_valid) begin
            cmd.load_mid = 1'b1;
            out_load     = 1'b1;
          end
          if (stat.scan_last) begin
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_final = 1'b1;
          out_load       = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/pts_dp.sv]
module pts_dp #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pts_pkg::cmd_t                 cmd,
  output pts_pkg::stat_t                stat,
  input  logic [pts_pkg::OP_W-1:0]      op,
  input  logic [pts_pkg::TASK_ID_W-1:0] task_id,
  input  logic [pts_pkg::TIME_W-1:0]    start_delay,
  input  logic [pts_pkg::TIME_W-1:0]    period,
  input  logic                          start_active,
  output logic                          released,
  output logic [pts_pkg::REL_W-1:0]     released_task,
  output logic                          last,
  output logic [pts_pkg::STATUS_W-1:0]  status
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ID_W  = pts_pkg::TASK_ID_W;
  localparam int T_W   = pts_pkg::TIME_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TASKS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TASKS - 1);
  localparam logic [ID_W:0]    ID_LIM   = (ID_W + 1)'(MAX_TASKS);

  // latched request word
  logic [pts_pkg::OP_W-1:0] lat_op;
  logic [ID_W-1:0]          lat_id;
  logic [T_W-1:0]           lat_delay;
  logic [T_W-1:0]           lat_period;
  logic                     lat_start;

  // task table
  logic [T_W-1:0]       countdown [MAX_TASKS];
  logic [T_W-1:0]       reload_period [MAX_TASKS];
  logic [MAX_TASKS-1:0] active;
  logic [CNT_W-1:0]     task_count;

  // scan state
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] pend_idx;
  logic             pend_valid;

  logic [T_W-1:0]   cur_cd;
  logic [T_W-1:0]   cd_next;
  logic             hit;
  logic             full;
  logic             bad_id;
  logic [ID_W-1:0]  pend_wide;
  logic [IDX_W-1:0] new_slot;
  logic [IDX_W-1:0] id_slot;

  // current slot evaluation
  assign cur_cd    = countdown[idx];
  assign hit       = active[idx] && (cur_cd == '0);
  assign cd_next   = (hit ? reload_period[idx] : cur_cd) - T_W'(1);
  assign full      = (task_count == CNT_FULL);
  assign bad_id    = ({1'b0, lat_id} >= ID_LIM);
  assign pend_wide = ID_W'(pend_idx);
  assign new_slot  = task_count[IDX_W-1:0];
  assign id_slot   = lat_id[IDX_W-1:0];

  assign stat.hit        = hit;
  assign stat.scan_last  = (idx == IDX_LAST);
  assign stat.pend_valid = pend_valid;

  // request latch, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_op     <= op;
      lat_id     <= task_id;
      lat_delay  <= start_delay;
      lat_period <= period;
      lat_start  <= start_active;
    end
  end

  // table, scan and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        countdown[i]     <= '0;
        reload_period[i] <= '0;
      end
      active        <= '0;
      task_count    <= '0;
      idx           <= '0;
      pend_idx      <= '0;
      pend_valid    <= 1'b0;
      released      <= 1'b0;
      released_task <= '0;
      last          <= 1'b0;
      status        <= pts_pkg::ST_OK;
    end else begin
      if (cmd.latch) begin
        idx <= '0;
      end

      // create, suspend, resume
      if (cmd.apply) begin
        released      <= 1'b0;
        released_task <= '0;
        last          <= 1'b1;
        case (lat_op)
          pts_pkg::OP_CREATE: begin
            if (full) begin
              status <= pts_pkg::ST_FULL;
            end else begin
              countdown[new_slot]     <= lat_delay;
              reload_period[new_slot] <= lat_period;
              active[new_slot]        <= lat_start;
              task_count              <= task_count + CNT_W'(1);
              status                  <= pts_pkg::ST_OK;
            end
          end
          pts_pkg::OP_SUSPEND, pts_pkg::OP_RESUME: begin
            if (bad_id) begin
              status <= pts_pkg::ST_RANGE;
            end else begin
              active[id_slot] <= (lat_op == pts_pkg::OP_RESUME);
              status          <= pts_pkg::ST_OK;
            end
          end
          default: begin
            status <= pts_pkg::ST_OK;
          end
        endcase
      end

      // one slot per step
      if (cmd.step) begin
        if (active[idx]) begin
          countdown[idx] <= cd_next;
        end
        if (hit) begin
          pend_idx   <= idx;
          pend_valid <= 1'b1;
        end
        if (idx != IDX_LAST) begin
          idx <= idx + IDX_W'(1);
        end
      end

      // held release goes out once a later one shows up
      if (cmd.load_mid) begin
        released      <= 1'b1;
        released_task <= pend_wide[pts_pkg::REL_W-1:0];
        last          <= 1'b0;
        status        <= pts_pkg::ST_OK;
      end

      // closing tick word: last release or empty result
      if (cmd.load_final) begin
        released      <= pend_valid;
        released_task <= pend_valid ? pend_wide[pts_pkg::REL_W-1:0] : '0;
        last          <= 1'b1;
        status        <= pts_pkg::ST_OK;
        pend_valid    <= 1'b0;
      end
    end
  end

endmodule

[rtl/periodic_tick_task_scheduler_top.sv]
// create, suspend and resume: the result word is loaded in EXEC once the
//   output register is free, and the next request is taken back in IDLE.
// tick: one table slot per cycle unless a stalled output holds the scan at a
//   second release; the final word is loaded in DONE, the next request back
//   in IDLE, and a stalled output delays any result load.
// synchronous reset clears the table, task count, flags and output valid.
`include "periodic_tick_task_scheduler_top_defines.svh"

module periodic_tick_task_scheduler_top #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input logic     clk,
  input logic     rst,
  pts_req_if.sink   req,
  pts_rsp_if.source rsp
);

  pts_pkg::cmd_t  cmd;
  pts_pkg::stat_t stat;

  // sequencer
  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // task table and result word
  pts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (req.op),
    .task_id       (req.task_id),
    .start_delay   (req.start_delay),
    .period        (req.period),
    .start_active  (req.start_active),
    .released      (rsp.released),
    .released_task (rsp.released_task),
    .last          (rsp.last),
    .status        (rsp.status)
  );

  // checks
  `PTS_ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)
  `PTS_ASSERT_NOW(a_mid_is_release, clk, rst, rsp.valid && !rsp.last, rsp.released)
  `PTS_ASSERT_NOW(a_err_is_final, clk, rst, rsp.valid && rsp.status != pts_pkg::ST_OK,
                  rsp.last && !rsp.released)

endmodule
